// ===== rtl/wzad_pkg.sv =====
// Shared types and constants for the windowed z-score anomaly detector.
package wzad_pkg;

   typedef struct packed {
      logic        clear_window;
      logic [13:0] cpu_percent;
      logic [13:0] mem_percent;
      logic [31:0] disk_read_bytes;
      logic [31:0] disk_write_bytes;
      logic [31:0] net_rx_bytes;
      logic [31:0] net_tx_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  metric_code;
      logic [1:0]  severity;
      logic [31:0] current_value;
      logic [31:0] baseline_mean;
      logic [15:0] deviation_q8;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  window_length;
      logic [6:0]  min_samples;
      logic [15:0] threshold_q8;
      logic [15:0] medium_limit_q8;
      logic [15:0] high_limit_q8;
   } cfg_type;

   // Register indexes
   localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
   localparam logic [2:0] REG_MIN_SAMPLES   = 3'd1;
   localparam logic [2:0] REG_THRESHOLD     = 3'd2;
   localparam logic [2:0] REG_MEDIUM_LIMIT  = 3'd3;
   localparam logic [2:0] REG_HIGH_LIMIT    = 3'd4;

   localparam logic [6:0]  WINDOW_LENGTH_RESET = 7'd64;
   localparam logic [6:0]  MIN_SAMPLES_RESET   = 7'd5;
   localparam logic [15:0] THRESHOLD_RESET     = 16'd512;
   localparam logic [15:0] MEDIUM_LIMIT_RESET  = 16'd768;
   localparam logic [15:0] HIGH_LIMIT_RESET    = 16'd1024;

   localparam int         NUM_METRICS = 6;
   localparam logic [2:0] METRIC_LAST = 3'd5;
   localparam logic [13:0] PCT_MAX    = 14'd10000;

   localparam logic [1:0] SEV_LOW    = 2'd0;
   localparam logic [1:0] SEV_MEDIUM = 2'd1;
   localparam logic [1:0] SEV_HIGH   = 2'd2;

   localparam logic [3:0] KBIT_TOP = 4'd15;

   // Datapath operations
   localparam logic [4:0] OP_NONE        = 5'd0;
   localparam logic [4:0] OP_CLEAR       = 5'd1;
   localparam logic [4:0] OP_LOAD        = 5'd2;
   localparam logic [4:0] OP_METRIC_INIT = 5'd3;
   localparam logic [4:0] OP_READ        = 5'd4;
   localparam logic [4:0] OP_ACCUM       = 5'd5;
   localparam logic [4:0] OP_SQ_ADD      = 5'd6;
   localparam logic [4:0] OP_MUL_N_SUMSQ = 5'd7;
   localparam logic [4:0] OP_SAVE_T      = 5'd8;
   localparam logic [4:0] OP_FORM_Q      = 5'd9;
   localparam logic [4:0] OP_FORM_D      = 5'd10;
   localparam logic [4:0] OP_MUL_NM1     = 5'd11;
   localparam logic [4:0] OP_FORM_R      = 5'd12;
   localparam logic [4:0] OP_FORM_BASE   = 5'd13;
   localparam logic [4:0] OP_CMP_START   = 5'd14;
   localparam logic [4:0] OP_CMP_DONE    = 5'd15;
   localparam logic [4:0] OP_DIV_START   = 5'd16;
   localparam logic [4:0] OP_PUSH        = 5'd17;
   localparam logic [4:0] OP_NEXT_METRIC = 5'd18;
   localparam logic [4:0] OP_FLUSH       = 5'd19;

   // Compare selects
   localparam logic [1:0] CMP_THR  = 2'd0;
   localparam logic [1:0] CMP_HIGH = 2'd1;
   localparam logic [1:0] CMP_MED  = 2'd2;
   localparam logic [1:0] CMP_DEV  = 2'd3;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] cmp_sel;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic enough;
      logic last_entry;
      logic q_zero;
      logic nx_gt_sum;
      logic cmp_lt;
      logic kb_zero;
      logic push_ok;
      logic pend_valid;
      logic out_free;
      logic last_metric;
   } status_type;

endpackage

// ===== rtl/wzad_dp.sv =====
// Datapath: window memory, sums, shared shift-add multiplier, divider, result buffers.
module wzad_dp
   import wzad_pkg::*;
#(
   parameter int WINDOW_DEPTH    = 64,
   parameter int BYTE_COUNT_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int B         = BYTE_COUNT_BITS;
   localparam int AW        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int NW        = $clog2(WINDOW_DEPTH + 1);
   localparam int LW        = NW + 7;
   localparam int SW        = B + NW;
   localparam int WW        = 2 * B + 3 * NW + 32;
   localparam int DCW       = $clog2(SW + 1);
   localparam int MUL_DIGIT = 4;
   localparam int ROWW      = NUM_METRICS * B;

   function automatic logic [B-1:0] sat_bytes(input logic [31:0] v);
      logic [B+31:0] vx;
      logic [B+31:0] cap;
      vx = {{B{1'b0}}, v};
      cap = {{32{1'b0}}, {B{1'b1}}};
      sat_bytes = (vx > cap) ? cap[B-1:0] : vx[B-1:0];
   endfunction

   logic [ROWW-1:0] win_mem [WINDOW_DEPTH];
   logic [ROWW-1:0] rd_row_ff;
   logic [ROWW-1:0] row_wr;

   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in, newest_ff, newest_in;
   logic [NW-1:0] fill_ff, fill_in, n_ff, n_in, cnt_ff, cnt_in;
   logic          enough_ff, enough_in;
   logic [2:0]    metric_ff, metric_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [WW-1:0] sumsq_ff, sumsq_in, tmp_ff, tmp_in, q_ff, q_in;
   logic [WW-1:0] r_ff, r_in, base_ff, base_in;
   logic [B-1:0]  x0_ff, x0_in;
   logic [WW-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in, mul_acc_ff, mul_acc_in;
   logic [1:0]    sev_ff, sev_in;
   logic [15:0]   k_ff, k_in, trial_ff, trial_in;
   logic [3:0]    kb_ff, kb_in;
   logic [SW-1:0] div_num_ff, div_num_in;
   logic [NW:0]   div_rem_ff, div_rem_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic          pend_valid_ff, pend_valid_in;
   rsp_type       pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [13:0]   cpu_sat, mem_sat;
   logic [B-1:0]  x_sel;
   logic [WW-1:0] sum_ext, n_w, dval;
   logic [WW+MUL_DIGIT-1:0] part;
   logic [15:0]   trial;
   logic [31:0]   trial_sq;
   logic [NW:0]   rem_sh;
   logic [B+31:0] x0_wide;
   logic [SW+31:0] mean_wide;
   logic [AW-1:0] wp_next;
   logic [NW-1:0] fill_next;
   logic [LW-1:0] len_ext, fill_ext, n_ext;
   logic          out_free, cmp_lt, cmp_le;
   rsp_type       new_res;

   assign cpu_sat = (req_data.cpu_percent > PCT_MAX) ? PCT_MAX : req_data.cpu_percent;
   assign mem_sat = (req_data.mem_percent > PCT_MAX) ? PCT_MAX : req_data.mem_percent;
   assign row_wr  = {sat_bytes(req_data.net_tx_bytes), sat_bytes(req_data.net_rx_bytes),
                     sat_bytes(req_data.disk_write_bytes), sat_bytes(req_data.disk_read_bytes),
                     {{(B-14){1'b0}}, mem_sat}, {{(B-14){1'b0}}, cpu_sat}};

   assign x_sel    = rd_row_ff[metric_ff * B +: B];
   assign sum_ext  = WW'(sum_ff);
   assign n_w      = WW'(n_ff);
   assign dval     = mul_acc_ff - sum_ext;
   assign part     = mul_a_ff * mul_b_ff[MUL_DIGIT-1:0];
   assign trial_sq = {16'd0, trial} * {16'd0, trial};
   assign rem_sh   = {div_rem_ff[NW-1:0], div_num_ff[SW-1]};
   assign x0_wide  = {32'd0, x0_ff};
   assign mean_wide = {32'd0, div_num_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cmp_lt   = mul_acc_ff < r_ff;
   assign cmp_le   = mul_acc_ff <= r_ff;
   assign wp_next  = (wp_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign fill_next = (fill_ff < NW'(WINDOW_DEPTH)) ? fill_ff + 1'b1 : fill_ff;

   always_comb begin
      case (cmd.cmp_sel)
         CMP_THR:  trial = cfg.threshold_q8;
         CMP_HIGH: trial = cfg.high_limit_q8;
         CMP_MED:  trial = cfg.medium_limit_q8;
         default:  trial = k_ff | (16'd1 << kb_ff);
      endcase
   end

   always_comb begin
      len_ext = LW'(cfg.window_length);
      if (len_ext == '0) len_ext = LW'(1);
      if (len_ext > LW'(WINDOW_DEPTH)) len_ext = LW'(WINDOW_DEPTH);
      fill_ext = LW'(fill_next);
      n_ext = (fill_ext < len_ext) ? fill_ext : len_ext;
   end

   always_comb begin
      new_res.metric_code   = metric_ff;
      new_res.severity      = sev_ff;
      new_res.current_value = x0_wide[31:0];
      new_res.baseline_mean = mean_wide[31:0];
      new_res.deviation_q8  = k_ff;
      new_res.last_result   = 1'b0;
   end

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      newest_in = newest_ff;
      fill_in = fill_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      enough_in = enough_ff;
      metric_in = metric_ff;
      sum_in = sum_ff;
      sumsq_in = sumsq_ff;
      tmp_in = tmp_ff;
      q_in = q_ff;
      r_in = r_ff;
      base_in = base_ff;
      x0_in = x0_ff;
      sev_in = sev_ff;
      k_in = k_ff;
      kb_in = kb_ff;
      trial_in = trial_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      mul_acc_in = mul_acc_ff;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;

      // advance the multiplier one digit
      if (mul_b_ff != '0) begin
         mul_acc_in = mul_acc_ff + part[WW-1:0];
         mul_a_in = mul_a_ff << MUL_DIGIT;
         mul_b_in = mul_b_ff >> MUL_DIGIT;
      end

      // advance the divider one quotient bit
      if (div_cnt_ff != '0) begin
         if (rem_sh >= {1'b0, n_ff}) begin
            div_rem_in = rem_sh - {1'b0, n_ff};
            div_num_in = {div_num_ff[SW-2:0], 1'b1};
         end else begin
            div_rem_in = rem_sh;
            div_num_in = {div_num_ff[SW-2:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      case (cmd.op)
         OP_CLEAR: begin
            wp_in = '0;
            fill_in = '0;
         end
         OP_LOAD: begin
            newest_in = wp_ff;
            wp_in = wp_next;
            fill_in = fill_next;
            n_in = n_ext[NW-1:0];
            enough_in = (n_ext >= LW'(2)) && (n_ext >= LW'(cfg.min_samples));
            metric_in = '0;
         end
         OP_METRIC_INIT, OP_NEXT_METRIC: begin
            if (cmd.op == OP_NEXT_METRIC) metric_in = metric_ff + 1'b1;
            sum_in = '0;
            sumsq_in = '0;
            cnt_in = '0;
            rp_in = newest_ff;
         end
         OP_READ: begin
            rp_in = (rp_ff == '0) ? AW'(WINDOW_DEPTH - 1) : rp_ff - 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         OP_ACCUM: begin
            sum_in = sum_ff + SW'(x_sel);
            if (cnt_ff == NW'(1)) x0_in = x_sel;
            mul_a_in = WW'(x_sel);
            mul_b_in = WW'(x_sel);
            mul_acc_in = '0;
         end
         OP_SQ_ADD: sumsq_in = sumsq_ff + mul_acc_ff;
         OP_MUL_N_SUMSQ: begin
            mul_a_in = sumsq_ff;
            mul_b_in = n_w;
            mul_acc_in = '0;
         end
         OP_SAVE_T: begin
            tmp_in = mul_acc_ff;
            mul_a_in = sum_ext;
            mul_b_in = sum_ext;
            mul_acc_in = '0;
         end
         OP_FORM_Q: begin
            q_in = tmp_ff - mul_acc_ff;
            mul_a_in = WW'(x0_ff);
            mul_b_in = n_w;
            mul_acc_in = '0;
         end
         OP_FORM_D: begin
            mul_a_in = dval;
            mul_b_in = dval;
            mul_acc_in = '0;
         end
         OP_MUL_NM1: begin
            mul_a_in = mul_acc_ff;
            mul_b_in = n_w - 1'b1;
            mul_acc_in = '0;
         end
         OP_FORM_R: begin
            r_in = mul_acc_ff << 16;
            mul_a_in = q_ff;
            mul_b_in = n_w;
            mul_acc_in = '0;
         end
         OP_FORM_BASE: begin
            base_in = mul_acc_ff;
            k_in = '0;
            kb_in = KBIT_TOP;
            sev_in = SEV_LOW;
         end
         OP_CMP_START: begin
            trial_in = trial;
            mul_a_in = base_ff;
            mul_b_in = WW'(trial_sq);
            mul_acc_in = '0;
         end
         OP_CMP_DONE: begin
            case (cmd.cmp_sel)
               CMP_THR:  sev_in = SEV_LOW;
               CMP_HIGH: if (cmp_lt) sev_in = SEV_HIGH;
               CMP_MED:  if (cmp_lt && sev_ff == SEV_LOW) sev_in = SEV_MEDIUM;
               default: begin
                  if (cmp_le) k_in = trial_ff;
                  kb_in = kb_ff - 1'b1;
               end
            endcase
         end
         OP_DIV_START: begin
            div_num_in = sum_ff;
            div_rem_in = '0;
            div_cnt_in = DCW'(SW);
         end
         OP_PUSH: begin
            if (pend_valid_ff) begin
               rsp_in = pend_ff;
               rsp_valid_in = 1'b1;
            end
            pend_in = new_res;
            pend_valid_in = 1'b1;
         end
         OP_FLUSH: begin
            rsp_in = pend_ff;
            rsp_in.last_result = 1'b1;
            rsp_valid_in = 1'b1;
            pend_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) win_mem[wp_ff] <= row_wr;
      if (cmd.op == OP_READ) rd_row_ff <= win_mem[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         fill_ff <= '0;
         n_ff <= '0;
         enough_ff <= 1'b0;
         metric_ff <= '0;
         cnt_ff <= '0;
         mul_b_ff <= '0;
         div_cnt_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         n_ff <= n_in;
         enough_ff <= enough_in;
         metric_ff <= metric_in;
         cnt_ff <= cnt_in;
         mul_b_ff <= mul_b_in;
         div_cnt_ff <= div_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff <= rp_in;
      newest_ff <= newest_in;
      sum_ff <= sum_in;
      sumsq_ff <= sumsq_in;
      tmp_ff <= tmp_in;
      q_ff <= q_in;
      r_ff <= r_in;
      base_ff <= base_in;
      x0_ff <= x0_in;
      sev_ff <= sev_in;
      k_ff <= k_in;
      kb_ff <= kb_in;
      trial_ff <= trial_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
      mul_a_ff <= mul_a_in;
      mul_acc_ff <= mul_acc_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
   end

   always_comb begin
      status.mul_done    = (mul_b_ff == '0);
      status.div_done    = (div_cnt_ff == '0);
      status.enough      = enough_ff;
      status.last_entry  = (cnt_ff == n_ff);
      status.q_zero      = (q_ff == '0);
      status.nx_gt_sum   = (mul_acc_ff > sum_ext);
      status.cmp_lt      = cmp_lt;
      status.kb_zero     = (kb_ff == '0);
      status.push_ok     = !pend_valid_ff || out_free;
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
      status.last_metric = (metric_ff == METRIC_LAST);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUSH && pend_valid_ff) |-> out_free)
      else $error("pending result pushed into a full output register");

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NW'(WINDOW_DEPTH))
      else $error("fill count beyond window depth");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |=> (n_ff <= fill_ff) && (n_ff != '0))
      else $error("active window size inconsistent with fill count");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FLUSH) |=> rsp_valid_ff && rsp_ff.last_result && !pend_valid_ff)
      else $error("flush did not deliver the final result");

endmodule

// ===== rtl/wzad_ctrl.sv =====
// Controller: sequences window sweeps, statistics, compares and result delivery.
module wzad_ctrl
   import wzad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_clear,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CHECK = 5'd1;
   localparam logic [4:0] S_READ  = 5'd2;
   localparam logic [4:0] S_WAIT  = 5'd3;
   localparam logic [4:0] S_SQ    = 5'd4;
   localparam logic [4:0] S_Q1    = 5'd5;
   localparam logic [4:0] S_Q2    = 5'd6;
   localparam logic [4:0] S_Q3    = 5'd7;
   localparam logic [4:0] S_D1    = 5'd8;
   localparam logic [4:0] S_D2    = 5'd9;
   localparam logic [4:0] S_D3    = 5'd10;
   localparam logic [4:0] S_BASE  = 5'd11;
   localparam logic [4:0] S_CMP   = 5'd12;
   localparam logic [4:0] S_CMPW  = 5'd13;
   localparam logic [4:0] S_DIV   = 5'd14;
   localparam logic [4:0] S_DIVW  = 5'd15;
   localparam logic [4:0] S_PUSH  = 5'd16;
   localparam logic [4:0] S_NEXT  = 5'd17;
   localparam logic [4:0] S_FLUSH = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [1:0] sel_ff, sel_in;

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.cmp_sel = sel_ff;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_clear) begin
                  cmd.op = OP_CLEAR;
               end else begin
                  cmd.op = OP_LOAD;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.enough) begin
               cmd.op = OP_METRIC_INIT;
               state_in = S_READ;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_READ: begin
            cmd.op = OP_READ;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.op = OP_ACCUM;
            state_in = S_SQ;
         end
         S_SQ: begin
            if (status.mul_done) begin
               cmd.op = OP_SQ_ADD;
               state_in = status.last_entry ? S_Q1 : S_READ;
            end
         end
         S_Q1: begin
            cmd.op = OP_MUL_N_SUMSQ;
            state_in = S_Q2;
         end
         S_Q2: begin
            if (status.mul_done) begin
               cmd.op = OP_SAVE_T;
               state_in = S_Q3;
            end
         end
         S_Q3: begin
            if (status.mul_done) begin
               cmd.op = OP_FORM_Q;
               state_in = S_D1;
            end
         end
         S_D1: begin
            // drop the metric on a flat window or a newest value at or below the mean
            if (status.mul_done) begin
               if (status.q_zero || !status.nx_gt_sum) begin
                  state_in = S_NEXT;
               end else begin
                  cmd.op = OP_FORM_D;
                  state_in = S_D2;
               end
            end
         end
         S_D2: begin
            if (status.mul_done) begin
               cmd.op = OP_MUL_NM1;
               state_in = S_D3;
            end
         end
         S_D3: begin
            if (status.mul_done) begin
               cmd.op = OP_FORM_R;
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            if (status.mul_done) begin
               cmd.op = OP_FORM_BASE;
               sel_in = CMP_THR;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.op = OP_CMP_START;
            state_in = S_CMPW;
         end
         S_CMPW: begin
            if (status.mul_done) begin
               cmd.op = OP_CMP_DONE;
               case (sel_ff)
                  CMP_THR: begin
                     if (status.cmp_lt) begin
                        sel_in = CMP_HIGH;
                        state_in = S_CMP;
                     end else begin
                        state_in = S_NEXT;
                     end
                  end
                  CMP_HIGH: begin
                     sel_in = CMP_MED;
                     state_in = S_CMP;
                  end
                  CMP_MED: begin
                     sel_in = CMP_DEV;
                     state_in = S_CMP;
                  end
                  default: state_in = status.kb_zero ? S_DIV : S_CMP;
               endcase
            end
         end
         S_DIV: begin
            cmd.op = OP_DIV_START;
            state_in = S_DIVW;
         end
         S_DIVW: begin
            if (status.div_done) state_in = S_PUSH;
         end
         S_PUSH: begin
            if (status.push_ok) begin
               cmd.op = OP_PUSH;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (status.last_metric) begin
               state_in = S_FLUSH;
            end else begin
               cmd.op = OP_NEXT_METRIC;
               state_in = S_READ;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.op = OP_FLUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff <= CMP_THR;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
      end
   end

endmodule

// ===== rtl/windowed_zscore_anomaly_detector.sv =====
// Top level: configuration registers, controller and datapath.
//
//  channel  ports                        direction  carries
//  req      req_valid/req_ready/req_data in         one telemetry sample or a clear
//  rsp      rsp_valid/rsp_ready/rsp_data out        one anomaly result
//  csr      csr_valid/csr_ready/csr_*    in         register index and write data
//
//  When enough samples are held, a sample sweeps the active window of n entries once per
//  metric through the shared 4-bit-per-cycle multiplier. A clear empties the window and
//  leaves the block idle. Reset empties the window and loads register defaults.
//  req_ready is high only while idle; a full output register stalls result hand-off.
//  The window memory is read one entry at a time, each squared before the next is read.
module windowed_zscore_anomaly_detector
   import wzad_pkg::*;
#(
   parameter int WINDOW_DEPTH    = 64,
   parameter int BYTE_COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WINDOW_LENGTH: cfg_in.window_length   = csr_data[6:0];
            REG_MIN_SAMPLES:   cfg_in.min_samples     = csr_data[6:0];
            REG_THRESHOLD:     cfg_in.threshold_q8    = csr_data;
            REG_MEDIUM_LIMIT:  cfg_in.medium_limit_q8 = csr_data;
            REG_HIGH_LIMIT:    cfg_in.high_limit_q8   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length   <= WINDOW_LENGTH_RESET;
         cfg_ff.min_samples     <= MIN_SAMPLES_RESET;
         cfg_ff.threshold_q8    <= THRESHOLD_RESET;
         cfg_ff.medium_limit_q8 <= MEDIUM_LIMIT_RESET;
         cfg_ff.high_limit_q8   <= HIGH_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wzad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_clear (req_data.clear_window),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wzad_dp #(
      .WINDOW_DEPTH    (WINDOW_DEPTH),
      .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
